// ===== hdl/rhd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants for the run-length hex payload decoder.
// ----------------------------------------------------------------------------
package rhd_pkg;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] COUNT_BIAS = 8'd29;
    // Raw count characters accepted: bias plus 3 up to bias plus 97
    localparam logic [7:0] COUNT_LO   = 8'd32;
    localparam logic [7:0] COUNT_HI   = 8'd126;
    localparam int         COUNT_W    = 7;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_HEX = 2'd1;
    localparam logic [1:0] ST_BAD_CNT = 2'd2;
    localparam logic [1:0] ST_ODD_LEN = 2'd3;

    // Pairing state of the hex unit
    typedef struct packed {
        logic [3:0] high_nibble;
        logic       nibble_pending;
        logic [1:0] error_code;
    } hex_state_t;

    // Result of one pass through the hex unit
    typedef struct packed {
        hex_state_t next;
        logic       emit;
        logic [7:0] data_val;
    } hex_step_t;

endpackage

// ===== hdl/rhd_hex_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_hex_unit
// Shared step unit: decodes one expanded character as a hex digit and pairs
// it with a held high digit, updating the sticky error status.
// ----------------------------------------------------------------------------
module rhd_hex_unit
    import rhd_pkg::*;
(
    input  logic [7:0] ch,
    input  hex_state_t st,
    output hex_step_t  res
);

    logic       digit_ok;
    logic [3:0] digit;
    logic [7:0] diff_num;
    logic [7:0] diff_lc;
    logic [7:0] diff_uc;

    assign diff_num = ch - 8'h30;
    assign diff_lc  = ch - 8'h57;
    assign diff_uc  = ch - 8'h37;

    // Decode the digit value
    always_comb
    begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        if (ch inside {[8'h30 : 8'h39]})
        begin
            digit = diff_num[3:0];
        end
        else if (ch inside {[8'h61 : 8'h66]})
        begin
            digit = diff_lc[3:0];
        end
        else if (ch inside {[8'h41 : 8'h46]})
        begin
            digit = diff_uc[3:0];
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    // Pair digits; hold everything once an error is latched
    always_comb
    begin
        res.next     = st;
        res.emit     = 1'b0;
        res.data_val = {st.high_nibble, digit};
        if (st.error_code == ST_OK)
        begin
            if (!digit_ok)
            begin
                res.next.error_code = ST_BAD_HEX;
            end
            else if (!st.nibble_pending)
            begin
                res.next.high_nibble    = digit;
                res.next.nibble_pending = 1'b1;
            end
            else
            begin
                res.next.nibble_pending = 1'b0;
                res.emit                = 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rle_hex_payload_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_hex_payload_decoder_core
// Run-length expanding hex payload decoder with a streaming interface.
// ----------------------------------------------------------------------------
// Payload characters enter one transaction at a time, tlast on the final one.
// An ordinary character or a repeat mark is handled on its own; the count
// character after a mark is followed by one expansion per repeated character
// (3 to 97), since the single hex unit handles one expanded character per
// cycle; no input is taken meanwhile. The end transaction follows the last.
// Every step waits while the output register holds a result not yet taken.
// Output: a decoded byte has tuser high; the end transaction has tlast high
// and carries the status (0 ok, 1 bad hex digit, 2 bad count, 3 odd length).
// ----------------------------------------------------------------------------
module rle_hex_payload_decoder_core
    import rhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [9:8] status, rest zero
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // payload_end
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REPEAT = 2'd1;
    localparam logic [1:0] S_END    = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [7:0]         prev_char_reg, prev_char_next;
    logic               have_prev_reg, have_prev_next;
    logic               repeat_pending_reg, repeat_pending_next;
    hex_state_t         hex_reg, hex_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               last_reg, last_next;
    logic               valid_reg, valid_next;
    logic [7:0]         odata_reg, odata_next;
    logic [1:0]         ostatus_reg, ostatus_next;
    logic               obyte_reg, obyte_next;
    logic               oend_reg, oend_next;

    logic       slot_free;
    logic       accept;
    logic [7:0] unit_char;
    logic [7:0] count_raw;
    hex_step_t  step;

    assign slot_free = !valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign unit_char = (state_reg == S_REPEAT) ? prev_char_reg : s_tdata;
    assign count_raw = s_tdata - COUNT_BIAS;

    rhd_hex_unit u_hex
    (
        .ch  (unit_char),
        .st  (hex_reg),
        .res (step)
    );

    // Sequencer and result selection
    always_comb
    begin
        state_next          = state_reg;
        prev_char_next      = prev_char_reg;
        have_prev_next      = have_prev_reg;
        repeat_pending_next = repeat_pending_reg;
        hex_next            = hex_reg;
        count_next          = count_reg;
        last_next           = last_reg;
        valid_next          = valid_reg && !m_tready;
        odata_next          = odata_reg;
        ostatus_next        = ostatus_reg;
        obyte_next          = obyte_reg;
        oend_next           = oend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = s_tlast;
                    if (repeat_pending_reg)
                    begin
                        repeat_pending_next = 1'b0;
                        if ((s_tdata < COUNT_LO) || (s_tdata > COUNT_HI))
                        begin
                            if (hex_reg.error_code == ST_OK)
                            begin
                                hex_next.error_code = ST_BAD_CNT;
                            end
                            state_next = s_tlast ? S_END : S_IDLE;
                        end
                        else
                        begin
                            count_next = count_raw[COUNT_W-1:0];
                            state_next = S_REPEAT;
                        end
                    end
                    else if ((s_tdata == STAR_CHAR) && have_prev_reg && !s_tlast)
                    begin
                        repeat_pending_next = 1'b1;
                    end
                    else
                    begin
                        prev_char_next = s_tdata;
                        have_prev_next = 1'b1;
                        hex_next       = step.next;
                        if (step.emit)
                        begin
                            valid_next   = 1'b1;
                            odata_next   = step.data_val;
                            ostatus_next = ST_OK;
                            obyte_next   = 1'b1;
                            oend_next    = 1'b0;
                        end
                        state_next = s_tlast ? S_END : S_IDLE;
                    end
                end
            end

            S_REPEAT:
            begin
                if (slot_free)
                begin
                    hex_next   = step.next;
                    count_next = count_reg - 1'b1;
                    if (step.emit)
                    begin
                        valid_next   = 1'b1;
                        odata_next   = step.data_val;
                        ostatus_next = ST_OK;
                        obyte_next   = 1'b1;
                        oend_next    = 1'b0;
                    end
                    if (count_reg == {{(COUNT_W-1){1'b0}}, 1'b1})
                    begin
                        state_next = last_reg ? S_END : S_IDLE;
                    end
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    valid_next = 1'b1;
                    odata_next = 8'd0;
                    obyte_next = 1'b0;
                    oend_next  = 1'b1;
                    if ((hex_reg.error_code == ST_OK) && hex_reg.nibble_pending)
                    begin
                        ostatus_next = ST_ODD_LEN;
                    end
                    else
                    begin
                        ostatus_next = hex_reg.error_code;
                    end
                    // Clear for the next payload
                    prev_char_next      = 8'd0;
                    have_prev_next      = 1'b0;
                    repeat_pending_next = 1'b0;
                    hex_next            = '0;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            prev_char_reg      <= 8'd0;
            have_prev_reg      <= 1'b0;
            repeat_pending_reg <= 1'b0;
            hex_reg            <= '0;
            count_reg          <= '0;
            last_reg           <= 1'b0;
            valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            prev_char_reg      <= prev_char_next;
            have_prev_reg      <= have_prev_next;
            repeat_pending_reg <= repeat_pending_next;
            hex_reg            <= hex_next;
            count_reg          <= count_next;
            last_reg           <= last_next;
            valid_reg          <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        odata_reg   <= odata_next;
        ostatus_reg <= ostatus_next;
        obyte_reg   <= obyte_next;
        oend_reg    <= oend_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, ostatus_reg, odata_reg};
    assign m_tuser  = obyte_reg;
    assign m_tlast  = oend_reg;

endmodule
